// File: rtl/sdtw_pkg.sv
// Shared constants and types for the sliding DTW match search core.
// Used by sdtw_isqrt, sliding_dtw_match_search_core and the test bench; no dependencies.
`default_nettype none
package sdtw_pkg;

    localparam int QUERY_MAX   = 256;
    localparam int REF_MAX     = 4096;
    localparam int SMP_W       = 16;
    localparam int Q_AW        = $clog2(QUERY_MAX);
    localparam int R_AW        = $clog2(REF_MAX);
    localparam int QLEN_W      = 9;
    localparam int RLEN_W      = 13;
    localparam int STRIDE_W    = 8;
    localparam int COST_W      = 25;
    localparam int OFF_W       = 12;
    localparam int K_W         = 13;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    // local cost = isqrt(|a-b| << 15)
    localparam int RAD_W       = SMP_W + 15;
    localparam int ROOT_W      = (RAD_W + 1) / 2;
    localparam int SQ_W        = RAD_W + 1;
    localparam int SQRT_STEPS  = ROOT_W;
    localparam int SQRT_CNT_W  = $clog2(SQRT_STEPS);
    localparam logic [SQ_W-1:0] SQ_BIT0 = SQ_W'(1) << (2 * (ROOT_W - 1));

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
    localparam logic [OFF_W-1:0]  OFF_MAX  = {OFF_W{1'b1}};

    localparam logic [QLEN_W-1:0]   QLEN_RST   = QLEN_W'(256);
    localparam logic [RLEN_W-1:0]   RLEN_RST   = RLEN_W'(4096);
    localparam logic [STRIDE_W-1:0] STRIDE_RST = STRIDE_W'(10);

    localparam logic [1:0] REG_QLEN   = 2'd0;
    localparam logic [1:0] REG_RLEN   = 2'd1;
    localparam logic [1:0] REG_STRIDE = 2'd2;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_REF   = 1'b1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SETUP = 9'b000000010,
        S_ROW   = 9'b000000100,
        S_CELL  = 9'b000001000,
        S_DIFF  = 9'b000010000,
        S_SQRT  = 9'b000100000,
        S_ACC   = 9'b001000000,
        S_EVAL  = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

endpackage
`default_nettype wire

// File: rtl/sdtw_isqrt.sv
// Bit-serial integer square root, one result bit per cycle.
// Depends on sdtw_pkg for widths.
`default_nettype none
module sdtw_isqrt (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [sdtw_pkg::RAD_W-1:0]      i_radicand,
    output logic                                 o_done,
    output logic [sdtw_pkg::ROOT_W-1:0]          o_root
);

    logic                            r_run;
    logic                            r_done;
    logic [sdtw_pkg::SQRT_CNT_W-1:0] r_cnt;
    logic [sdtw_pkg::SQ_W-1:0]       r_x;
    logic [sdtw_pkg::SQ_W-1:0]       r_res;
    logic [sdtw_pkg::SQ_W-1:0]       r_bit;
    logic [sdtw_pkg::SQ_W-1:0]       w_trial;
    logic                            w_ge;

    assign w_trial = r_res + r_bit;
    assign w_ge    = (r_x >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == sdtw_pkg::SQRT_CNT_W'(sdtw_pkg::SQRT_STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= {1'b0, i_radicand};
            r_res <= '0;
            r_bit <= sdtw_pkg::SQ_BIT0;
        end else if (r_run) begin
            if (w_ge) begin
                r_x   <= r_x - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[sdtw_pkg::ROOT_W-1:0];

endmodule
`default_nettype wire

// File: rtl/sliding_dtw_match_search_core.sv
// Sliding DTW match search: loads query and reference samples one per cycle while not
// busy, then on the last reference sample scores every window offset by full DTW (or
// sets status if the query is longer than the reference). Per DTW cell: store reads,
// difference, bit-serial square root, accumulate; per row a reference read and per
// offset an evaluation step; busy stays high meanwhile. The result strobe is a single
// cycle and cannot be stalled. Reset (sync, low) clears control and the registers to
// their defaults; the sample stores do not.
`default_nettype none
module sliding_dtw_match_search_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               i_operation,
    input  wire logic signed [sdtw_pkg::SMP_W-1:0]  i_sample,
    input  wire logic                               i_last,
    output logic                                    o_done,
    output logic [sdtw_pkg::OFF_W-1:0]              o_best_offset,
    output logic [sdtw_pkg::COST_W-1:0]             o_best_cost,
    output logic                                    o_status,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [sdtw_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [sdtw_pkg::DATA_W-1:0]        pwdata,
    output logic [sdtw_pkg::DATA_W-1:0]             prdata,
    output logic                                    pready
);

    localparam int QW = sdtw_pkg::QLEN_W;
    localparam int RW = sdtw_pkg::RLEN_W;
    localparam int SW = sdtw_pkg::STRIDE_W;
    localparam int CW = sdtw_pkg::COST_W;

    // configuration
    logic [QW-1:0] r_qlen;
    logic [RW-1:0] r_rlen;
    logic [SW-1:0] r_stride;
    logic          w_cfg_wr;

    // control
    sdtw_pkg::t_state r_state;
    logic [QW-1:0]              r_qcnt;
    logic [RW-1:0]              r_rcnt;
    logic [sdtw_pkg::Q_AW-1:0]  r_i;
    logic [sdtw_pkg::Q_AW-1:0]  r_j;
    logic [RW-1:0]              r_base;
    logic [sdtw_pkg::K_W-1:0]   r_k;

    // datapath
    logic [CW-1:0]                  r_left;
    logic [CW-1:0]                  r_diag;
    logic [CW-1:0]                  r_up;
    logic [CW-1:0]                  r_best;
    logic [sdtw_pkg::OFF_W-1:0]     r_best_idx;
    logic                           r_status;
    logic                           r_done;

    // stores
    logic [sdtw_pkg::SMP_W-1:0] m_query [sdtw_pkg::QUERY_MAX];
    logic [sdtw_pkg::SMP_W-1:0] m_ref   [sdtw_pkg::REF_MAX];
    logic [CW-1:0]              m_row   [sdtw_pkg::QUERY_MAX];
    logic [sdtw_pkg::SMP_W-1:0] r_q_rd;
    logic [sdtw_pkg::SMP_W-1:0] r_ref_rd;
    logic [CW-1:0]              r_row_rd;

    logic                       w_accept;
    logic                       w_q_we;
    logic                       w_r_we;
    logic [QW-1:0]              w_q_eff;
    logic [RW-1:0]              w_r_eff;
    logic [SW-1:0]              w_st_eff;
    logic [sdtw_pkg::Q_AW-1:0]  w_q_m1;
    logic [RW-1:0]              w_ref_addr;
    logic [RW:0]                w_next_base;
    logic                       w_more;
    logic signed [sdtw_pkg::SMP_W:0] w_diff;
    logic [sdtw_pkg::SMP_W-1:0] w_abs;
    logic [sdtw_pkg::RAD_W-1:0] w_rad;
    logic                       w_sq_start;
    logic                       w_sq_done;
    logic [sdtw_pkg::ROOT_W-1:0] w_root;
    logic [CW-1:0]              w_min;
    logic [CW-1:0]              w_base_cost;
    logic [CW:0]                w_sum;
    logic [CW-1:0]              w_val;
    logic                       w_take;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen   <= sdtw_pkg::QLEN_RST;
            r_rlen   <= sdtw_pkg::RLEN_RST;
            r_stride <= sdtw_pkg::STRIDE_RST;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                sdtw_pkg::REG_QLEN:   r_qlen   <= pwdata[QW-1:0];
                sdtw_pkg::REG_RLEN:   r_rlen   <= pwdata[RW-1:0];
                sdtw_pkg::REG_STRIDE: r_stride <= pwdata[SW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            sdtw_pkg::REG_QLEN:   prdata = sdtw_pkg::DATA_W'(r_qlen);
            sdtw_pkg::REG_RLEN:   prdata = sdtw_pkg::DATA_W'(r_rlen);
            sdtw_pkg::REG_STRIDE: prdata = sdtw_pkg::DATA_W'(r_stride);
            default:              prdata = '0;
        endcase
    end

    // clamped lengths
    always_comb begin
        w_q_eff = r_qlen;
        if (r_qlen == '0) begin
            w_q_eff = QW'(1);
        end else if (r_qlen > QW'(sdtw_pkg::QUERY_MAX)) begin
            w_q_eff = QW'(sdtw_pkg::QUERY_MAX);
        end
        w_r_eff = r_rlen;
        if (r_rlen == '0) begin
            w_r_eff = RW'(1);
        end else if (r_rlen > RW'(sdtw_pkg::REF_MAX)) begin
            w_r_eff = RW'(sdtw_pkg::REF_MAX);
        end
        w_st_eff = (r_stride == '0) ? SW'(1) : r_stride;
    end

    assign w_q_m1      = sdtw_pkg::Q_AW'(w_q_eff - 1'b1);
    assign w_ref_addr  = r_base + RW'(r_i);
    assign w_next_base = (RW+1)'(r_base) + (RW+1)'(w_st_eff);
    assign w_more      = (w_next_base + (RW+1)'(w_q_eff)) <= (RW+1)'(w_r_eff);

    // ---------------- loading ----------------
    assign busy     = (r_state != sdtw_pkg::S_IDLE);
    assign w_accept = start && !busy;
    assign w_q_we   = w_accept && (i_operation == sdtw_pkg::OP_QUERY)
                      && (r_qcnt < QW'(sdtw_pkg::QUERY_MAX));
    assign w_r_we   = w_accept && (i_operation == sdtw_pkg::OP_REF)
                      && (r_rcnt < RW'(sdtw_pkg::REF_MAX));

    always_ff @(posedge i_clk) begin
        if (w_q_we) begin
            m_query[r_qcnt[sdtw_pkg::Q_AW-1:0]] <= i_sample;
        end
        if (r_state == sdtw_pkg::S_CELL) begin
            r_q_rd <= m_query[r_j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_r_we) begin
            m_ref[r_rcnt[sdtw_pkg::R_AW-1:0]] <= i_sample;
        end
        if (r_state == sdtw_pkg::S_ROW) begin
            r_ref_rd <= m_ref[w_ref_addr[sdtw_pkg::R_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sdtw_pkg::S_ACC) begin
            m_row[r_j] <= w_val;
        end
        if (r_state == sdtw_pkg::S_CELL) begin
            r_row_rd <= m_row[r_j];
        end
    end

    // ---------------- local cost ----------------
    assign w_diff     = {r_ref_rd[sdtw_pkg::SMP_W-1], r_ref_rd}
                      - {r_q_rd[sdtw_pkg::SMP_W-1], r_q_rd};
    assign w_abs      = w_diff[sdtw_pkg::SMP_W] ? sdtw_pkg::SMP_W'(-w_diff)
                                                : w_diff[sdtw_pkg::SMP_W-1:0];
    assign w_rad      = {w_abs, 15'b0};
    assign w_sq_start = (r_state == sdtw_pkg::S_DIFF);

    sdtw_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sq_start),
        .i_radicand (w_rad),
        .o_done     (w_sq_done),
        .o_root     (w_root)
    );

    // ---------------- accumulation ----------------
    always_comb begin
        w_min = r_left;
        if (w_min > r_diag) begin
            w_min = r_diag;
        end
        if (r_up < w_min) begin
            w_min = r_up;
        end
        if (r_i == '0 && r_j == '0) begin
            w_base_cost = '0;
        end else if (r_i == '0) begin
            w_base_cost = r_left;
        end else if (r_j == '0) begin
            w_base_cost = r_up;
        end else begin
            w_base_cost = w_min;
        end
        w_sum = {1'b0, w_base_cost} + (CW+1)'(w_root);
        w_val = w_sum[CW] ? sdtw_pkg::COST_MAX : w_sum[CW-1:0];
    end

    assign w_take = (r_k == '0) || (r_left < r_best);

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sdtw_pkg::S_IDLE;
            r_qcnt     <= '0;
            r_rcnt     <= '0;
            r_done     <= 1'b0;
            r_i        <= '0;
            r_j        <= '0;
            r_base     <= '0;
            r_k        <= '0;
            r_best     <= sdtw_pkg::COST_MAX;
            r_best_idx <= '0;
            r_status   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                sdtw_pkg::S_IDLE: begin
                    if (w_accept && i_operation == sdtw_pkg::OP_REF && i_last) begin
                        r_qcnt  <= '0;
                        r_rcnt  <= '0;
                        r_state <= sdtw_pkg::S_SETUP;
                    end else begin
                        if (w_q_we) begin
                            r_qcnt <= r_qcnt + 1'b1;
                        end
                        if (w_r_we) begin
                            r_rcnt <= r_rcnt + 1'b1;
                        end
                    end
                end
                sdtw_pkg::S_SETUP: begin
                    r_best_idx <= '0;
                    r_i        <= '0;
                    r_j        <= '0;
                    r_base     <= '0;
                    r_k        <= '0;
                    if (RW'(w_q_eff) > w_r_eff) begin
                        r_best   <= '0;
                        r_status <= 1'b1;
                        r_state  <= sdtw_pkg::S_FIN;
                    end else begin
                        r_best   <= sdtw_pkg::COST_MAX;
                        r_status <= 1'b0;
                        r_state  <= sdtw_pkg::S_ROW;
                    end
                end
                sdtw_pkg::S_ROW:  r_state <= sdtw_pkg::S_CELL;
                sdtw_pkg::S_CELL: r_state <= sdtw_pkg::S_DIFF;
                sdtw_pkg::S_DIFF: r_state <= sdtw_pkg::S_SQRT;
                sdtw_pkg::S_SQRT: begin
                    if (w_sq_done) begin
                        r_state <= sdtw_pkg::S_ACC;
                    end
                end
                sdtw_pkg::S_ACC: begin
                    if (r_j != w_q_m1) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= sdtw_pkg::S_CELL;
                    end else if (r_i != w_q_m1) begin
                        r_j     <= '0;
                        r_i     <= r_i + 1'b1;
                        r_state <= sdtw_pkg::S_ROW;
                    end else begin
                        r_state <= sdtw_pkg::S_EVAL;
                    end
                end
                sdtw_pkg::S_EVAL: begin
                    // r_left holds the corner cell of the finished table
                    if (w_take) begin
                        r_best     <= r_left;
                        r_best_idx <= (r_k > sdtw_pkg::K_W'(sdtw_pkg::OFF_MAX))
                                      ? sdtw_pkg::OFF_MAX : r_k[sdtw_pkg::OFF_W-1:0];
                    end
                    if (w_more) begin
                        r_base  <= w_next_base[RW-1:0];
                        r_k     <= r_k + 1'b1;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= sdtw_pkg::S_ROW;
                    end else begin
                        r_state <= sdtw_pkg::S_FIN;
                    end
                end
                sdtw_pkg::S_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= sdtw_pkg::S_IDLE;
                end
                default: r_state <= sdtw_pkg::S_IDLE;
            endcase
        end
    end

    // neighbor registers along the row
    always_ff @(posedge i_clk) begin
        if (r_state == sdtw_pkg::S_DIFF) begin
            r_up <= r_row_rd;
        end
        if (r_state == sdtw_pkg::S_ACC) begin
            r_left <= w_val;
            r_diag <= r_up;
        end
    end

    assign o_done        = r_done;
    assign o_best_offset = r_best_idx;
    assign o_best_cost   = r_best;
    assign o_status      = r_status;

    // ---------------- assertions ----------------
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_last_starts_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == sdtw_pkg::OP_REF && i_last) |=> busy)
        else $error("last reference sample did not start a search");

    a_cell_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sdtw_pkg::S_ACC) |-> (r_i <= w_q_m1 && r_j <= w_q_m1))
        else $error("DTW cell index beyond query length");

    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("busy while presenting a result");

endmodule
`default_nettype wire

// File: test/sdtw_match_checker.sv
// Scoreboard for sliding_dtw_match_search_core: mirrors the sample stores and the
// config registers, predicts best offset/cost per search request and checks results.
// Depends on sdtw_pkg for widths, register indexes and operation codes.
module sdtw_match_checker
    import sdtw_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic                      i_busy,
    input  wire logic                      i_operation,
    input  wire logic signed [SMP_W-1:0]   i_sample,
    input  wire logic                      i_last,
    input  wire logic                      i_done,
    input  wire logic [OFF_W-1:0]          i_best_offset,
    input  wire logic [COST_W-1:0]         i_best_cost,
    input  wire logic                      i_status,
    input  wire logic                      i_psel,
    input  wire logic                      i_penable,
    input  wire logic                      i_pwrite,
    input  wire logic [ADDR_W-1:0]         i_paddr,
    input  wire logic [DATA_W-1:0]         i_pwdata,
    input  wire logic                      i_pready,
    output int                             o_pending,
    output int                             o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [COST_W-1:0] cost;
        logic              status;
    } t_match;

    logic signed [SMP_W-1:0] query_mem [QUERY_MAX];
    logic signed [SMP_W-1:0] ref_mem [REF_MAX];
    logic [QLEN_W-1:0]       qlen_reg;
    logic [RLEN_W-1:0]       rlen_reg;
    logic [STRIDE_W-1:0]     stride_reg;
    int                      query_fill;
    int                      ref_fill;
    int                      errors = 0;
    t_match                  expected_matches [$];
    t_match                  want;

    function automatic logic [COST_W-1:0] cap_sum(logic [COST_W-1:0] a, logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? COST_MAX : s[COST_W-1:0];
    endfunction

    // floor(sqrt(|a-b| << 15)), bit by bit
    function automatic logic [COST_W-1:0] sample_distance(logic signed [SMP_W-1:0] a,
                                                          logic signed [SMP_W-1:0] b);
        longint          diff;
        longint unsigned rad;
        longint unsigned root;
        longint unsigned probe;
        diff = longint'(a) - longint'(b);
        if (diff < 0) diff = -diff;
        rad   = longint'(diff) << 15;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > rad) probe = probe >> 2;
        while (probe != 0) begin
            if (rad >= root + probe) begin
                rad  = rad - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root[COST_W-1:0];
    endfunction

    // full DTW between query[0..qn-1] and the reference window at base, one row kept
    function automatic logic [COST_W-1:0] warp_cost(int base, int qn);
        logic [COST_W-1:0]       row [QUERY_MAX];
        logic [COST_W-1:0]       diag;
        logic [COST_W-1:0]       up;
        logic [COST_W-1:0]       m;
        logic [COST_W-1:0]       d;
        logic signed [SMP_W-1:0] r;
        for (int i = 0; i < qn; i++) begin
            r    = ref_mem[(base + i) % REF_MAX];
            diag = row[0];
            for (int j = 0; j < qn; j++) begin
                d = sample_distance(r, query_mem[j]);
                if (i == 0 && j == 0) begin
                    row[0] = d;
                end else if (i == 0) begin
                    row[j] = cap_sum(row[j-1], d);
                end else if (j == 0) begin
                    row[0] = cap_sum(row[0], d);
                end else begin
                    up = row[j];
                    m  = row[j-1];
                    if (m > diag) m = diag;
                    if (up < m) m = up;
                    diag   = up;
                    row[j] = cap_sum(m, d);
                end
            end
        end
        return row[qn-1];
    endfunction

    function automatic t_match predict_search();
        int                q;
        int                r;
        int                st;
        int                n;
        int                best_k;
        logic [COST_W-1:0] c;
        logic [COST_W-1:0] best;
        t_match            res;
        res = '0;
        q  = int'(qlen_reg);
        if (q < 1) q = 1;
        if (q > QUERY_MAX) q = QUERY_MAX;
        r  = int'(rlen_reg);
        if (r < 1) r = 1;
        if (r > REF_MAX) r = REF_MAX;
        st = (stride_reg == 0) ? 1 : int'(stride_reg);
        if (r < q) begin
            res.status = 1'b1;
            return res;
        end
        n      = (r - q) / st + 1;
        best   = COST_MAX;
        best_k = 0;
        for (int k = 0; k < n; k++) begin
            c = warp_cost(k * st, q);
            // strict compare keeps the earliest offset on a tie
            if (k == 0 || c < best) begin
                best   = c;
                best_k = k;
            end
        end
        res.offset = (best_k > int'(OFF_MAX)) ? OFF_MAX : best_k[OFF_W-1:0];
        res.cost   = best;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            qlen_reg   = QLEN_RST;
            rlen_reg   = RLEN_RST;
            stride_reg = STRIDE_RST;
            query_fill = 0;
            ref_fill   = 0;
            expected_matches.delete();
        end else begin
            if (i_done) begin
                if (expected_matches.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result: offset %0d cost %0d status %0d",
                                 $realtime, i_best_offset, i_best_cost, i_status);
                end else begin
                    want = expected_matches.pop_front();
                    if (want.offset !== i_best_offset || want.cost !== i_best_cost ||
                        want.status !== i_status) begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: result mismatch: expected offset %0d cost %0d ",
                                      "status %0d, got offset %0d cost %0d status %0d"},
                                     $realtime, want.offset, want.cost, want.status,
                                     i_best_offset, i_best_cost, i_status);
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (i_operation == OP_QUERY) begin
                    if (query_fill < QUERY_MAX) begin
                        query_mem[query_fill] = i_sample;
                        query_fill++;
                    end
                end else begin
                    if (ref_fill < REF_MAX) begin
                        ref_mem[ref_fill] = i_sample;
                        ref_fill++;
                    end
                    if (i_last) begin
                        expected_matches = {expected_matches, predict_search()};
                        query_fill = 0;
                        ref_fill   = 0;
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_QLEN:   qlen_reg   = i_pwdata[QLEN_W-1:0];
                    REG_RLEN:   rlen_reg   = i_pwdata[RLEN_W-1:0];
                    REG_STRIDE: stride_reg = i_pwdata[STRIDE_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending <= expected_matches.size();
        o_errors  <= errors;
    end

endmodule

// File: test/tb_top.sv
// Top-level bench for sliding_dtw_match_search_core: drives sample requests and
// APB config writes, runs directed and random search jobs, and reports the verdict.
// Depends on sdtw_pkg, the core RTL and sdtw_match_checker.
module tb_top;
    import sdtw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 10;
    localparam int RANDOM_ITEMS   = 500;
    localparam int WATCHDOG_LIMIT = 200000;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    start       = 1'b0;
    logic                    i_operation = OP_QUERY;
    logic signed [SMP_W-1:0] i_sample    = '0;
    logic                    i_last      = 1'b0;
    logic                    psel        = 1'b0;
    logic                    penable     = 1'b0;
    logic                    pwrite      = 1'b0;
    logic [ADDR_W-1:0]       paddr       = '0;
    logic [DATA_W-1:0]       pwdata      = '0;

    wire logic               busy;
    wire logic               o_done;
    wire logic [OFF_W-1:0]   o_best_offset;
    wire logic [COST_W-1:0]  o_best_cost;
    wire logic               o_status;
    wire logic [DATA_W-1:0]  prdata;
    wire logic               pready;

    int pending;
    int errors;
    int idle_pct    = 0;
    int items_sent  = 0;
    int quiet_count = 0;
    int idle_plan [4] = '{0, 46, 0, 17};

    always #(CLK_HALF) i_clk = ~i_clk;

    sliding_dtw_match_search_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_sample      (i_sample),
        .i_last        (i_last),
        .o_done        (o_done),
        .o_best_offset (o_best_offset),
        .o_best_cost   (o_best_cost),
        .o_status      (o_status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    sdtw_match_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_operation   (i_operation),
        .i_sample      (i_sample),
        .i_last        (i_last),
        .i_done        (o_done),
        .i_best_offset (o_best_offset),
        .i_best_cost   (o_best_cost),
        .i_status      (o_status),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_pending     (pending),
        .o_errors      (errors)
    );

    // watchdog: cycles in which neither channel nor the config port moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (psel && penable && pwrite && pready)) begin
            quiet_count <= 0;
        end else if (quiet_count + 1 >= WATCHDOG_LIMIT) begin
            $display("[sliding_dtw_match_search_core] ERROR");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    function automatic logic signed [SMP_W-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            1, 2:    return SMP_W'(int'($urandom_range(7)) - 4);  // near-equal values, ties
            default: return SMP_W'($urandom);
        endcase
    endfunction

    // all tasks start and return on a falling edge
    task automatic push_sample(input logic op, input logic signed [SMP_W-1:0] smp,
                               input logic lst);
        while ($urandom_range(99) < idle_pct) begin
            start       <= 1'b0;
            i_operation <= 1'($urandom);
            i_sample    <= SMP_W'($urandom);
            i_last      <= 1'($urandom);
            @(negedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_sample    <= smp;
        i_last      <= lst;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // hold off requests until every search result is back and the core is idle
    task automatic settle();
        start <= 1'b0;
        while (pending != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic configure(input int qlen, input int rlen, input int stride);
        settle();
        write_reg(REG_QLEN, qlen);
        write_reg(REG_RLEN, rlen);
        write_reg(REG_STRIDE, stride);
    endtask

    // query load then reference load; a broken job ends early or never sets last
    task automatic run_window_job(input int qn, input int rn, input bit broken);
        int cut;
        cut = broken ? $urandom_range(rn) : rn - 1;
        for (int i = 0; i < qn; i++)
            push_sample(OP_QUERY, pick_sample(), $urandom_range(7) == 0);
        for (int i = 0; i < rn; i++) begin
            push_sample(OP_REF, pick_sample(), i == cut);
            if (i == cut) break;
        end
    endtask

    task automatic noise_burst();
        int len;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
            push_sample(1'($urandom), pick_sample(), $urandom_range(3) == 0);
    endtask

    initial begin
        int base;
        int phase;
        int phase_end;
        int q_set;
        int r_set;
        int st_set;
        int qn;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // fill the query store past its depth; clamped query length, ten offsets of one sample
        configure(0, 48, 5);
        for (int i = 0; i < QUERY_MAX + 4; i++)
            push_sample(OP_QUERY, (i == 0) ? 16'sh7fff : (i == 2) ? 16'sh8000 : pick_sample(),
                        i == 1);
        for (int i = 0; i < 48; i++)
            push_sample(OP_REF, pick_sample(), i == 47);

        // reference shorter than query: at the largest query and with clamped values
        configure(QUERY_MAX, 255, 1);
        push_sample(OP_REF, 16'sh0000, 1'b1);
        configure(511, 0, 0);
        push_sample(OP_REF, 16'sh0001, 1'b1);

        // single-cell windows at full-scale and zero differences
        configure(1, 0, 0);
        push_sample(OP_QUERY, 16'sh7fff, 1'b0);
        push_sample(OP_REF, 16'sh8000, 1'b1);
        push_sample(OP_QUERY, 16'sh8000, 1'b0);
        push_sample(OP_REF, 16'sh7fff, 1'b1);
        push_sample(OP_QUERY, 16'sh0000, 1'b1);
        push_sample(OP_REF, 16'sh0000, 1'b1);

        // equal costs keep the first offset; a later strict minimum wins
        configure(1, 3, 1);
        push_sample(OP_QUERY, 16'sd5, 1'b0);
        for (int i = 0; i < 3; i++) push_sample(OP_REF, 16'sd5, i == 2);
        push_sample(OP_QUERY, 16'sd7, 1'b0);
        push_sample(OP_REF, 16'sd100, 1'b0);
        push_sample(OP_REF, 16'sd7, 1'b0);
        push_sample(OP_REF, 16'sd7, 1'b1);

        configure(2, 48, 15);
        push_sample(OP_QUERY, 16'sh7fff, 1'b0);
        push_sample(OP_QUERY, 16'sh8000, 1'b0);
        push_sample(OP_REF, 16'sh1234, 1'b1);

        base  = items_sent;
        phase = 0;
        while (items_sent - base < RANDOM_ITEMS) begin
            q_set = $urandom_range(1, 6);
            if ($urandom_range(9) == 0) q_set = $urandom_range(7, 12);
            r_set = q_set + ((q_set > 6) ? $urandom_range(0, 8) : $urandom_range(0, 24));
            if (q_set > 1 && $urandom_range(7) == 0) r_set = $urandom_range(1, q_set - 1);
            st_set = $urandom_range(1, 4);
            if ($urandom_range(5) == 0) st_set = $urandom_range(5, 255);
            if ($urandom_range(9) == 0) st_set = 0;
            configure(q_set, r_set, st_set);
            idle_pct  = idle_plan[phase % 4];
            phase_end = items_sent + $urandom_range(40, 70);
            while (items_sent < phase_end) begin
                if ($urandom_range(4) != 0) begin
                    qn = q_set;
                    if ($urandom_range(7) == 0) qn = $urandom_range(0, q_set + 2);
                    run_window_job(qn, r_set, $urandom_range(5) == 0);
                    if ($urandom_range(4) == 0) settle();
                end else begin
                    noise_burst();
                end
            end
            phase++;
        end

        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("[sliding_dtw_match_search_core] OK");
        end else begin
            $display("[sliding_dtw_match_search_core] ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/sdtw_pkg.sv
rtl/sdtw_isqrt.sv
rtl/sliding_dtw_match_search_core.sv
test/sdtw_match_checker.sv
test/tb_top.sv
